// ----- rtl/core/prs_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority round scheduler package
// Shared widths, codes and structures of the scheduler's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

    // Task table size and the widths that follow from it.
    localparam int MAX_SLOTS    = 16;
    localparam int SLOT_W       = $clog2(MAX_SLOTS);
    localparam int COUNT_W      = $clog2(MAX_SLOTS + 1);

    // Field widths of requests and results.
    localparam int PRIO_W       = 8;
    localparam int WORK_W       = 16;
    localparam int SLOT_FIELD_W = 4;
    localparam int KIND_W       = 2;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 48;

    // Request action codes.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_ROUND = 1'b1;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_SERVE = 2'd1,
        KIND_IDLE  = 2'd2
    } t_kind;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PLACE,
        ST_ACK,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // Write controls from the sequencer into the task table.
    typedef struct packed {
        logic              task_we;
        logic [SLOT_W-1:0] task_slot;
        logic [PRIO_W-1:0] task_prio;
        logic [WORK_W-1:0] task_work;
        logic              left_we;
        logic [SLOT_W-1:0] left_slot;
        logic [WORK_W-1:0] left_val;
        logic              order_we;
        logic [SLOT_W-1:0] order_pos;
        logic [SLOT_W-1:0] order_slot;
    } t_tbl_wr;

    // One result item.
    typedef struct packed {
        t_kind                   kind;
        logic                    accepted;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [PRIO_W-1:0]       prio;
        logic [WORK_W-1:0]       step;
        logic [WORK_W-1:0]       total;
        logic                    last;
    } t_result;

    // Low bits of a slot index as reported in a result.
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
        wide = {{SLOT_FIELD_W{1'b0}}, s};
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/prs_table.sv -----
// ----------------------------------------------------------------------------
// Priority round scheduler task table
// Per-slot priority, remaining and total counts, plus the service order list.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_table (
    input  wire logic                          i_clk,
    input  wire prs_pkg::t_tbl_wr              i_wr,
    input  wire logic [prs_pkg::SLOT_W-1:0]    i_rd_pos,
    output logic      [prs_pkg::SLOT_W-1:0]    o_rd_slot,
    output logic      [prs_pkg::PRIO_W-1:0]    o_rd_prio,
    output logic      [prs_pkg::WORK_W-1:0]    o_rd_left,
    output logic      [prs_pkg::WORK_W-1:0]    o_rd_total
);

    logic [prs_pkg::PRIO_W-1:0] r_prio  [prs_pkg::MAX_SLOTS];
    logic [prs_pkg::WORK_W-1:0] r_left  [prs_pkg::MAX_SLOTS];
    logic [prs_pkg::WORK_W-1:0] r_total [prs_pkg::MAX_SLOTS];
    logic [prs_pkg::SLOT_W-1:0] r_order [prs_pkg::MAX_SLOTS];

    // New tasks and remaining-count updates.
    always_ff @(posedge i_clk) begin
        if (i_wr.task_we) begin
            r_prio[i_wr.task_slot]  <= i_wr.task_prio;
            r_left[i_wr.task_slot]  <= i_wr.task_work;
            r_total[i_wr.task_slot] <= i_wr.task_work;
        end else if (i_wr.left_we) begin
            r_left[i_wr.left_slot] <= i_wr.left_val;
        end
    end

    // Service order list.
    always_ff @(posedge i_clk) begin
        if (i_wr.order_we) begin
            r_order[i_wr.order_pos] <= i_wr.order_slot;
        end
    end

    // Look up the slot at a list position, then that slot's entry.
    always_comb begin
        o_rd_slot  = r_order[i_rd_pos];
        o_rd_prio  = r_prio[o_rd_slot];
        o_rd_left  = r_left[o_rd_slot];
        o_rd_total = r_total[o_rd_slot];
    end

endmodule

`default_nettype wire

// ----- rtl/core/prs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Priority round scheduler sequencer
// Walks the order list one position per cycle, pausing on an output stall,
// with shared arithmetic: sorted insertion on add, in-order service on a round.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic [prs_pkg::PRIO_W-1:0]    i_prio,
    input  wire logic [prs_pkg::WORK_W-1:0]    i_work,
    output prs_pkg::t_tbl_wr                   o_wr,
    output logic      [prs_pkg::SLOT_W-1:0]    o_rd_pos,
    input  wire logic [prs_pkg::SLOT_W-1:0]    i_rd_slot,
    input  wire logic [prs_pkg::PRIO_W-1:0]    i_rd_prio,
    input  wire logic [prs_pkg::WORK_W-1:0]    i_rd_left,
    input  wire logic [prs_pkg::WORK_W-1:0]    i_rd_total,
    output logic                               o_res_valid,
    output prs_pkg::t_result                   o_res,
    input  wire logic                          i_res_ready
);

    prs_pkg::t_state                r_state, n_state;
    logic [prs_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [prs_pkg::SLOT_W-1:0]     r_pos, n_pos;
    logic [prs_pkg::PRIO_W-1:0]     r_new_prio, n_new_prio;
    logic [prs_pkg::SLOT_W-1:0]     r_new_slot, n_new_slot;
    logic                           r_accepted, n_accepted;
    logic                           r_hold_valid, n_hold_valid;
    prs_pkg::t_result               r_hold, n_hold;

    logic [prs_pkg::COUNT_W-1:0]    cnt_m1;
    logic [prs_pkg::WORK_W-1:0]     step_num;
    logic [prs_pkg::WORK_W-1:0]     left_dec;
    logic                           at_end;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= prs_pkg::ST_IDLE;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_new_prio <= n_new_prio;
        r_new_slot <= n_new_slot;
        r_accepted <= n_accepted;
        r_hold     <= n_hold;
    end

    // Shared arithmetic on the entry at the current list position.
    always_comb begin
        cnt_m1   = r_count - prs_pkg::COUNT_W'(1);
        step_num = i_rd_total - i_rd_left + prs_pkg::WORK_W'(1);
        left_dec = i_rd_left - prs_pkg::WORK_W'(1);
        at_end   = (prs_pkg::COUNT_W'(r_pos) + prs_pkg::COUNT_W'(1)) == r_count;
    end

    // Next state and outputs.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_new_prio   = r_new_prio;
        n_new_slot   = r_new_slot;
        n_accepted   = r_accepted;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        o_in_ready   = 1'b0;
        o_wr         = '0;
        o_rd_pos     = r_pos;
        o_res_valid  = 1'b0;
        o_res        = '0;

        case (r_state)
            prs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == prs_pkg::ACT_ADD) begin
                        if (r_count < prs_pkg::COUNT_W'(prs_pkg::MAX_SLOTS)) begin
                            // Store the task; its list place is found by walking back, or is the head of an empty list.
                            o_wr.task_we   = 1'b1;
                            o_wr.task_slot = r_count[prs_pkg::SLOT_W-1:0];
                            o_wr.task_prio = i_prio;
                            o_wr.task_work = i_work;
                            n_count        = r_count + prs_pkg::COUNT_W'(1);
                            n_new_slot     = r_count[prs_pkg::SLOT_W-1:0];
                            n_new_prio     = i_prio;
                            n_accepted     = 1'b1;
                            if (r_count == '0) begin
                                o_wr.order_we   = 1'b1;
                                o_wr.order_pos  = '0;
                                o_wr.order_slot = '0;
                                n_state         = prs_pkg::ST_ACK;
                            end else begin
                                n_pos   = cnt_m1[prs_pkg::SLOT_W-1:0];
                                n_state = prs_pkg::ST_INSERT;
                            end
                        end else begin
                            n_accepted = 1'b0;
                            n_state    = prs_pkg::ST_ACK;
                        end
                    end else begin
                        n_pos        = '0;
                        n_hold_valid = 1'b0;
                        n_state      = (r_count == '0) ? prs_pkg::ST_FLUSH : prs_pkg::ST_SCAN;
                    end
                end
            end

            prs_pkg::ST_INSERT: begin
                // Entries of lower priority move up one place; equal ones stay ahead.
                o_wr.order_we  = 1'b1;
                o_wr.order_pos = r_pos + prs_pkg::SLOT_W'(1);
                if (i_rd_prio < r_new_prio) begin
                    o_wr.order_slot = i_rd_slot;
                    if (r_pos == '0) begin
                        n_state = prs_pkg::ST_PLACE;
                    end else begin
                        n_pos = r_pos - prs_pkg::SLOT_W'(1);
                    end
                end else begin
                    o_wr.order_slot = r_new_slot;
                    n_state         = prs_pkg::ST_ACK;
                end
            end

            prs_pkg::ST_PLACE: begin
                // The new task heads the list.
                o_wr.order_we   = 1'b1;
                o_wr.order_pos  = '0;
                o_wr.order_slot = r_new_slot;
                n_state         = prs_pkg::ST_ACK;
            end

            prs_pkg::ST_ACK: begin
                o_res_valid    = 1'b1;
                o_res.kind     = prs_pkg::KIND_ADD;
                o_res.accepted = r_accepted;
                o_res.last     = 1'b1;
                if (i_res_ready) begin
                    n_state = prs_pkg::ST_IDLE;
                end
            end

            prs_pkg::ST_SCAN: begin
                // An active entry is held back until the next one shows it was not last.
                if (i_rd_left != '0) begin
                    if (!r_hold_valid || i_res_ready) begin
                        o_res_valid    = r_hold_valid;
                        o_res          = r_hold;
                        o_res.last     = 1'b0;
                        n_hold_valid   = 1'b1;
                        n_hold.kind    = prs_pkg::KIND_SERVE;
                        n_hold.accepted = 1'b0;
                        n_hold.slot    = prs_pkg::slot_field(i_rd_slot);
                        n_hold.prio    = i_rd_prio;
                        n_hold.step    = step_num;
                        n_hold.total   = i_rd_total;
                        n_hold.last    = 1'b0;
                        o_wr.left_we   = 1'b1;
                        o_wr.left_slot = i_rd_slot;
                        o_wr.left_val  = left_dec;
                        if (at_end) begin
                            n_state = prs_pkg::ST_FLUSH;
                        end else begin
                            n_pos = r_pos + prs_pkg::SLOT_W'(1);
                        end
                    end
                end else begin
                    if (at_end) begin
                        n_state = prs_pkg::ST_FLUSH;
                    end else begin
                        n_pos = r_pos + prs_pkg::SLOT_W'(1);
                    end
                end
            end

            prs_pkg::ST_FLUSH: begin
                // Final served task, or the idle answer when nothing was active.
                o_res_valid = 1'b1;
                if (r_hold_valid) begin
                    o_res = r_hold;
                end else begin
                    o_res.kind = prs_pkg::KIND_IDLE;
                end
                o_res.last = 1'b1;
                if (i_res_ready) begin
                    n_hold_valid = 1'b0;
                    n_state      = prs_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = prs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/priority_round_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// Priority round scheduler
// Task table with sorted insertion and static-priority service rounds.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser selects add (0) or round (1);
//   an add carries the task priority and work count in tdata.
//   Results leave on the m_axis channel, one request giving one or more results;
//   tlast marks the final result of each request.
//   An add takes the new task into a list kept sorted by descending priority,
//   walking back one list entry per cycle.
//   A round walks the list one entry per cycle, pausing on an output stall,
//   and serves each task with work left; each list entry takes one table read.
//   s_axis tready is high only while no request is in progress.
//   Results pass through one output register, and the sequencer keeps one more
//   result pending behind it; a stalled receiver holds the register, and the
//   walk pauses while both are full.
//   Reset empties the table and drops any request in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_round_scheduler_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: prio [7:0], work [23:8]
    input  wire logic [prs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: action [0]
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: accepted [0], slot [4:1], served_prio [12:5], step_number [28:13],
    //        step_total [44:29], zero fill [47:45]
    output logic      [prs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: kind [1:0]
    output logic      [prs_pkg::KIND_W-1:0]         o_m_axis_tuser,
    output logic                                    o_m_axis_tlast
);

    prs_pkg::t_tbl_wr               tbl_wr;
    logic [prs_pkg::SLOT_W-1:0]     rd_pos;
    logic [prs_pkg::SLOT_W-1:0]     rd_slot;
    logic [prs_pkg::PRIO_W-1:0]     rd_prio;
    logic [prs_pkg::WORK_W-1:0]     rd_left;
    logic [prs_pkg::WORK_W-1:0]     rd_total;
    logic                           res_valid;
    logic                           res_ready;
    prs_pkg::t_result               res;

    logic                           r_out_valid;
    prs_pkg::t_result               r_out;

    prs_table u_table (
        .i_clk      (i_clk),
        .i_wr       (tbl_wr),
        .i_rd_pos   (rd_pos),
        .o_rd_slot  (rd_slot),
        .o_rd_prio  (rd_prio),
        .o_rd_left  (rd_left),
        .o_rd_total (rd_total)
    );

    prs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_prio      (i_s_axis_tdata[7:0]),
        .i_work      (i_s_axis_tdata[23:8]),
        .o_wr        (tbl_wr),
        .o_rd_pos    (rd_pos),
        .i_rd_slot   (rd_slot),
        .i_rd_prio   (rd_prio),
        .i_rd_left   (rd_left),
        .i_rd_total  (rd_total),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Output register: loads when empty or when its content is being taken.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    // Pack the result fields onto the master channel.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.total, r_out.step, r_out.prio,
                              r_out.slot, r_out.accepted};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

// ----- rtl/core/prs_checker.sv -----
// ----------------------------------------------------------------------------
// Priority round scheduler checker
// Port-level assertions on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    input  wire logic                               i_s_axis_tready,
    input  wire logic                               i_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    input  wire logic [prs_pkg::OUT_TDATA_W-1:0]    i_m_axis_tdata,
    input  wire logic [prs_pkg::KIND_W-1:0]         i_m_axis_tuser,
    input  wire logic                               i_m_axis_tlast
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser)
            && $stable(i_m_axis_tlast))
        else $error("stalled result changed");

    // One request at a time: an accepted request closes the input.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("request accepted while another is in progress");

    // An add acknowledge is a single result carrying only the accepted flag.
    a_add_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (i_m_axis_tuser == prs_pkg::KIND_ADD) |->
            i_m_axis_tlast && (i_m_axis_tdata[prs_pkg::OUT_TDATA_W-1:1] == '0))
        else $error("malformed add acknowledge");

    // An idle round is a single all-zero result.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (i_m_axis_tuser == prs_pkg::KIND_IDLE) |->
            i_m_axis_tlast && (i_m_axis_tdata == '0))
        else $error("malformed idle result");

    // A served step lies between one and the task's total.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (i_m_axis_tuser == prs_pkg::KIND_SERVE) |->
            (i_m_axis_tdata[28:13] != '0) && (i_m_axis_tdata[28:13] <= i_m_axis_tdata[44:29])
            && !i_m_axis_tdata[0])
        else $error("served step out of range");

endmodule

bind priority_round_scheduler_top prs_checker u_prs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
